// ===== rtl/barometric_altitude_with_ground_cal_top_macros.svh =====
// Assertion macros shared by the barometric altitude checker.
// Needs nothing else; included by files that carry concurrent assertions.
`ifndef BAROMETRIC_ALTITUDE_WITH_GROUND_CAL_TOP_MACROS_SVH
`define BAROMETRIC_ALTITUDE_WITH_GROUND_CAL_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BA_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/baro_alt_pkg.sv =====
// Constants, command codes and the power table generator for the barometric altitude block.
// Depends on nothing; imported by the interfaces, the top level and the checker.
`default_nettype none

package baro_alt_pkg;

  localparam int RATIO_W       = 17;  // width of the Q16 pressure ratio
  localparam int FRAC_W        = 17;  // interpolation fraction bits
  localparam int TAB_W         = 17;  // width of one power table entry
  localparam int ALT_W         = 21;
  localparam int GND_W         = 17;
  localparam int CFG_W         = 8;
  localparam int SAMPLE_CNT_W  = 8;
  localparam int Q16_SHIFT     = 16;
  localparam int MUL_A_W       = 22;
  localparam int MUL_B_W       = 18;
  localparam int MUL_W         = MUL_A_W + MUL_B_W;

  localparam logic              CMD_CLEAR       = 1'b1;
  localparam logic [CFG_W-1:0]  AVG_SAMPLES_RST = 8'd60;
  localparam logic [RATIO_W-1:0] RATIO_MAX      = 17'h1FFFF;
  localparam logic [MUL_B_W-1:0] ONE_Q16        = 18'd65536;

  localparam logic signed [MUL_A_W-1:0] ALT_SCALE    = 22'sd1454396;
  localparam logic signed [MUL_W-1:0]   ROUND_Q16    = 40'sd32768;
  localparam logic signed [MUL_W-1:0]   ALT_MAX_WIDE = 40'sd999990;
  localparam logic signed [MUL_W-1:0]   ALT_MIN_WIDE = -40'sd999990;
  localparam logic signed [ALT_W-1:0]   ALT_MAX      = 21'sd999990;
  localparam logic signed [ALT_W-1:0]   ALT_MIN      = -21'sd999990;

  localparam longint EXP_NUM = 64'sd1903;
  localparam longint EXP_DEN = 64'sd10000;

  // Integer square root, one result bit per pass.
  function automatic longint unsigned isqrt_u64(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned res;
    longint unsigned bit_v;
    v     = v_in;
    res   = 64'd0;
    bit_v = 64'h4000_0000_0000_0000;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 64'd0) begin
      if (v >= res + bit_v) begin
        v   = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Base-two logarithm in Q32 by repeated squaring of the normalized mantissa.
  function automatic longint unsigned log2_q32(input longint unsigned n);
    int              p;
    int              k;
    longint unsigned m;
    longint unsigned frac;
    p    = 0;
    frac = 64'd0;
    while ((p < 62) && ((n >> (p + 1)) != 64'd0)) p++;
    if (p <= 31) m = n << (31 - p);
    else         m = n >> (p - 31);
    for (k = 31; k >= 0; k--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m    = m >> 1;
        frac = frac | (64'd1 << k);
      end
    end
    return (64'(p) << 32) | frac;
  endfunction

  // Entry idx of the Q16 table of (2*idx/segs)^0.1903, built with exact integer steps.
  function automatic logic [TAB_W-1:0] pow_entry(input int segs, input int idx);
    longint unsigned roots [0:31];
    longint unsigned ls;
    longint unsigned yy;
    longint unsigned f;
    longint unsigned acc;
    longint          l;
    longint          y;
    int              k;
    int              sh;
    int              j;
    if (idx == 0) return '0;
    roots[0] = isqrt_u64(64'h8000_0000_0000_0000);
    for (j = 1; j < 32; j++) roots[j] = isqrt_u64(roots[j-1] << 31);
    ls  = log2_q32(64'(segs));
    l   = $signed(log2_q32(64'(2 * idx))) - $signed(ls);
    y   = (l * EXP_NUM) / EXP_DEN;
    yy  = $unsigned(y + (64'sd16 <<< 32));
    k   = int'(yy >> 32) - 16;
    f   = yy & 64'hFFFF_FFFF;
    acc = 64'h8000_0000;
    for (j = 0; j < 32; j++) begin
      if (((f >> (31 - j)) & 64'd1) != 64'd0) begin
        acc = (acc * roots[j] + 64'h4000_0000) >> 31;
      end
    end
    sh = 15 - k;
    if (sh < 1)  sh = 1;
    if (sh > 62) sh = 62;
    return TAB_W'((acc + (64'd1 << (sh - 1))) >> sh);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/baro_alt_if.sv =====
// Valid/ready channel interfaces for the barometric altitude block: samples, results, config.
// Depends on baro_alt_pkg for the field widths.
`default_nettype none

interface baro_alt_in_if
  import baro_alt_pkg::*;
#(
  parameter int PRESSURE_BITS = 17
) ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [PRESSURE_BITS-1:0] pressure_pa;

  modport source (output valid, output cmd, output pressure_pa, input ready);
  modport sink   (input valid, input cmd, input pressure_pa, output ready);
endinterface

interface baro_alt_out_if
  import baro_alt_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [ALT_W-1:0] altitude_tenth_ft;
  logic                    calibrated;
  logic [GND_W-1:0]        ground_pa;

  modport source (output valid, output altitude_tenth_ft, output calibrated,
                  output ground_pa, input ready);
  modport sink   (input valid, input altitude_tenth_ft, input calibrated,
                  input ground_pa, output ready);
endinterface

interface baro_alt_cfg_if
  import baro_alt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/barometric_altitude_with_ground_cal_top.sv =====
// Barometric altitude above an averaged ground reference; uses baro_alt_pkg and baro_alt_if.
// The sequencer takes a clear or an uncalibrated sample from ST_IDLE to ST_DONE, and the next
// sample is taken once ST_DONE has handed its result on and returned to ST_IDLE. A calibrated
// sample runs ST_R_START, the ratio divider ST_R_DIV (a pressure at or above twice ground skips
// it), then ST_MUL_U through ST_ALT and ST_DONE; the sample that completes calibration first runs ST_AVG_DIV.
// Reset (rst_n low, synchronous) clears calibration, sums, altitude and sets avg_samples to 60.
`default_nettype none

module barometric_altitude_with_ground_cal_top
  import baro_alt_pkg::*;
#(
  parameter int POW_SEGMENTS  = 512,
  parameter int PRESSURE_BITS = 17
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  baro_alt_cfg_if.sink   cfg_if,
  baro_alt_in_if.sink    in_if,
  baro_alt_out_if.source out_if
);

  // Widths that follow from the parameters. The shared divider's quotient register must hold
  // both the PRESSURE_BITS-bit ground average and the 17-bit ratio.
  localparam int PB    = PRESSURE_BITS;
  localparam int SUM_W = PB + SAMPLE_CNT_W;
  localparam int QW    = (PB > RATIO_W) ? PB : RATIO_W;
  localparam int CNT_W = $clog2(QW + 1);
  localparam int IDX_W = $clog2(POW_SEGMENTS + 1);

  // Sequencer codes.
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_AVG_DIV = 4'd1;
  localparam logic [3:0] ST_R_START = 4'd2;
  localparam logic [3:0] ST_R_DIV   = 4'd3;
  localparam logic [3:0] ST_MUL_U   = 4'd4;
  localparam logic [3:0] ST_INDEX   = 4'd5;
  localparam logic [3:0] ST_ROM_LO  = 4'd6;
  localparam logic [3:0] ST_ROM_HI  = 4'd7;
  localparam logic [3:0] ST_MUL_F   = 4'd8;
  localparam logic [3:0] ST_Q_SUM   = 4'd9;
  localparam logic [3:0] ST_MUL_ALT = 4'd10;
  localparam logic [3:0] ST_ALT     = 4'd11;
  localparam logic [3:0] ST_DONE    = 4'd12;

  // The power curve is a synchronous ROM of POW_SEGMENTS+1 entries, generated at elaboration.
  typedef logic [TAB_W-1:0] pow_tab_t [0:POW_SEGMENTS];

  function automatic pow_tab_t build_pow_tab();
    pow_tab_t tab;
    for (int i = 0; i <= POW_SEGMENTS; i++) tab[i] = pow_entry(POW_SEGMENTS, i);
    return tab;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

  // Control state.
  logic [3:0]              state_r;
  logic [CFG_W-1:0]        avg_samples_r;
  logic                    cal_done_r;
  logic [SUM_W-1:0]        press_sum_r;
  logic [SAMPLE_CNT_W-1:0] sample_count_r;
  logic [PB-1:0]           ground_ref_r;
  logic signed [ALT_W-1:0] last_alt_r;
  logic                    out_valid_r;

  // Datapath registers.
  logic [PB-1:0]              press_r;
  logic [PB-1:0]              rem_r;
  logic [QW-1:0]              quo_r;
  logic [PB-1:0]              div_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [IDX_W-1:0]           idx_r;
  logic [FRAC_W-1:0]          frac_r;
  logic [TAB_W-1:0]           lo_r;
  logic [TAB_W-1:0]           rom_q_r;
  logic signed [MUL_B_W-1:0]  qv_r;
  logic signed [MUL_W-1:0]    mul_r;
  logic signed [ALT_W-1:0]    out_alt_r;
  logic                       out_cal_r;
  logic [GND_W-1:0]           out_gnd_r;

  // Combinational helpers.
  logic [PB-1:0]             press_in;
  logic [SUM_W-1:0]          sum_nxt;
  logic [SAMPLE_CNT_W-1:0]   count_nxt;
  logic                      avg_reached;
  logic                      out_free;
  logic                      ratio_sat;
  logic [PB:0]               div_trial;
  logic [PB:0]               div_diff;
  logic                      div_bit;
  logic [PB-1:0]             rem_nxt;
  logic [QW-1:0]             quo_nxt;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_W-1:0]   mul_p;
  logic [IDX_W-1:0]          u_idx;
  logic [IDX_W-1:0]          idx_clamp;
  logic [IDX_W-1:0]          rom_addr;
  logic [TAB_W:0]            q_sum;
  logic signed [MUL_W-1:0]   alt_round;
  logic signed [MUL_W-1:0]   alt_shift;
  logic signed [ALT_W-1:0]   alt_sat;

  // Handshakes. Configuration is always taken; a sample is taken only by an idle sequencer,
  // while a finished result may still sit in the output register.
  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = (state_r == ST_IDLE);
  assign out_free     = !out_valid_r || out_if.ready;

  assign out_if.valid             = out_valid_r;
  assign out_if.altitude_tenth_ft = out_alt_r;
  assign out_if.calibrated        = out_cal_r;
  assign out_if.ground_pa         = out_gnd_r;

  // Ground averaging: running sum and count of nonzero samples.
  assign press_in    = PB'(in_if.pressure_pa);
  assign sum_nxt     = press_sum_r + SUM_W'(press_in);
  assign count_nxt   = sample_count_r + SAMPLE_CNT_W'(1);
  assign avg_reached = (count_nxt >= avg_samples_r) && (count_nxt != '0);

  // The ratio P*2^16/P0 fits in 17 bits exactly when P < 2*P0; otherwise it saturates and the
  // divider is skipped. A zero ground reference also lands on the saturated side.
  assign ratio_sat = ({1'b0, press_r} >= {ground_ref_r, 1'b0});

  // Shared restoring divider: one quotient bit per cycle. The dividend bits still to come sit
  // at the top of quo_r and the quotient bits enter at the bottom.
  assign div_trial = {rem_r, quo_r[QW-1]};
  assign div_diff  = div_trial - {1'b0, div_r};
  assign div_bit   = (div_trial >= {1'b0, div_r});
  assign rem_nxt   = div_bit ? div_diff[PB-1:0] : div_trial[PB-1:0];
  assign quo_nxt   = {quo_r[QW-2:0], div_bit};

  // Shared signed multiplier, registered into mul_r. It forms u = r * POW_SEGMENTS, then the
  // interpolation product (hi - lo) * f, then the altitude product 1454396 * (1 - q).
  always_comb begin
    unique case (state_r)
      ST_MUL_U: begin
        mul_a = $signed(MUL_A_W'(quo_r[RATIO_W-1:0]));
        mul_b = $signed(MUL_B_W'(POW_SEGMENTS));
      end
      ST_MUL_F: begin
        mul_a = (rom_q_r >= lo_r) ? $signed(MUL_A_W'(rom_q_r - lo_r)) : '0;
        mul_b = $signed(MUL_B_W'(frac_r));
      end
      default: begin
        mul_a = ALT_SCALE;
        mul_b = qv_r;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Segment index and the table's upper neighbor for interpolation.
  assign u_idx     = mul_r[RATIO_W+IDX_W-1:RATIO_W];
  assign idx_clamp = (u_idx >= IDX_W'(POW_SEGMENTS)) ? IDX_W'(POW_SEGMENTS - 1) : u_idx;
  assign rom_addr  = (state_r == ST_ROM_HI) ? (idx_r + IDX_W'(1)) : idx_r;

  // Interpolated power q = lo + floor((hi - lo) * f / 2^17).
  assign q_sum = {1'b0, lo_r} + {1'b0, mul_r[FRAC_W+TAB_W-1:FRAC_W]};

  // Altitude = floor((product + 2^15) / 2^16), clamped to the display range.
  assign alt_round = mul_r + ROUND_Q16;
  assign alt_shift = alt_round >>> Q16_SHIFT;

  always_comb begin
    if (alt_shift > ALT_MAX_WIDE) begin
      alt_sat = ALT_MAX;
    end else if (alt_shift < ALT_MIN_WIDE) begin
      alt_sat = ALT_MIN;
    end else begin
      alt_sat = $signed(alt_shift[ALT_W-1:0]);
    end
  end

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      avg_samples_r  <= AVG_SAMPLES_RST;
      cal_done_r     <= 1'b0;
      press_sum_r    <= '0;
      sample_count_r <= '0;
      ground_ref_r   <= '0;
      last_alt_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        avg_samples_r <= cfg_if.data;
      end
      // A new result is loaded as soon as the output register is free; otherwise a taken
      // result empties it.
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_if.valid) begin
            if (in_if.cmd == CMD_CLEAR) begin
              // A clear drops calibration and altitude and reports all zeros.
              cal_done_r     <= 1'b0;
              press_sum_r    <= '0;
              sample_count_r <= '0;
              ground_ref_r   <= '0;
              last_alt_r     <= '0;
              state_r        <= ST_DONE;
            end else if (!cal_done_r && (press_in != '0)) begin
              press_sum_r    <= sum_nxt;
              sample_count_r <= count_nxt;
              state_r        <= avg_reached ? ST_AVG_DIV : ST_DONE;
            end else if (cal_done_r) begin
              state_r <= ST_R_START;
            end else begin
              // Zero pressure before calibration is ignored.
              state_r <= ST_DONE;
            end
          end
        end
        ST_AVG_DIV: begin
          if (cnt_r == CNT_W'(1)) begin
            // The sample that completes calibration is also turned into an altitude.
            ground_ref_r <= quo_nxt[PB-1:0];
            cal_done_r   <= 1'b1;
            state_r      <= ST_R_START;
          end
        end
        ST_R_START: state_r <= ratio_sat ? ST_MUL_U : ST_R_DIV;
        ST_R_DIV: begin
          if (cnt_r == CNT_W'(1)) begin
            state_r <= ST_MUL_U;
          end
        end
        ST_MUL_U:   state_r <= ST_INDEX;
        ST_INDEX:   state_r <= ST_ROM_LO;
        ST_ROM_LO:  state_r <= ST_ROM_HI;
        ST_ROM_HI:  state_r <= ST_MUL_F;
        ST_MUL_F:   state_r <= ST_Q_SUM;
        ST_Q_SUM:   state_r <= ST_MUL_ALT;
        ST_MUL_ALT: state_r <= ST_ALT;
        ST_ALT: begin
          last_alt_r <= alt_sat;
          state_r    <= ST_DONE;
        end
        ST_DONE: begin
          // Wait here only while the previous result has not been taken.
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers; none of them needs a reset.
  always_ff @(posedge clk) begin
    rom_q_r <= POW_TAB[rom_addr];
    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          // Preload the divider for sum / count; used only if this sample ends averaging.
          press_r <= press_in;
          rem_r   <= PB'(sum_nxt[SUM_W-1:PB]);
          quo_r   <= QW'(sum_nxt[PB-1:0]) << (QW - PB);
          div_r   <= PB'(count_nxt);
          cnt_r   <= CNT_W'(PB);
        end
      end
      ST_AVG_DIV, ST_R_DIV: begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      ST_R_START: begin
        if (ratio_sat) begin
          quo_r <= QW'(RATIO_MAX);
        end else begin
          // Dividend P*2^16: its bits above 17 are P>>1, the rest are P[0] then zeros.
          rem_r <= press_r >> 1;
          quo_r <= QW'({press_r[0], {(RATIO_W-1){1'b0}}}) << (QW - RATIO_W);
          div_r <= ground_ref_r;
          cnt_r <= CNT_W'(RATIO_W);
        end
      end
      ST_MUL_U, ST_MUL_F, ST_MUL_ALT: begin
        mul_r <= mul_p;
      end
      ST_INDEX: begin
        idx_r  <= idx_clamp;
        frac_r <= mul_r[FRAC_W-1:0];
      end
      ST_ROM_HI: begin
        lo_r <= rom_q_r;
      end
      ST_Q_SUM: begin
        qv_r <= $signed(ONE_Q16 - MUL_B_W'(q_sum));
      end
      ST_DONE: begin
        if (out_free) begin
          out_alt_r <= last_alt_r;
          out_cal_r <= cal_done_r;
          out_gnd_r <= GND_W'(ground_ref_r);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/baro_alt_checker.sv =====
// Port-level checks for the barometric altitude block, bound to its top level.
// Depends on baro_alt_pkg and the assertion macro header.
`default_nettype none

`include "barometric_altitude_with_ground_cal_top_macros.svh"

module baro_alt_checker
  import baro_alt_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [ALT_W-1:0] out_alt,
  input wire logic                    out_cal,
  input wire logic [GND_W-1:0]        out_gnd
);

  // Every reported altitude lies inside the saturation limits.
  `BA_ASSERT_NOW(a_alt_range, clk, rst_n, out_valid, (out_alt <= ALT_MAX) && (out_alt >= ALT_MIN), "altitude outside saturation range")

  // Before calibration both altitude and ground reference read zero.
  `BA_ASSERT_NOW(a_uncal_zero, clk, rst_n, out_valid && !out_cal, (out_alt == '0) && (out_gnd == '0), "uncalibrated result is not zero")

  // One transaction at a time: the input closes right after an acceptance.
  `BA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "input ready right after acceptance")

  // A stalled result stays put.
  `BA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_alt) && $stable(out_cal) && $stable(out_gnd), "stalled result changed")

endmodule

bind barometric_altitude_with_ground_cal_top baro_alt_checker u_baro_alt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_alt   (out_if.altitude_tenth_ft),
  .out_cal   (out_if.calibrated),
  .out_gnd   (out_if.ground_pa)
);

`default_nettype wire
